### hw/rtl/fmacl_pkg.sv
// fmacl_pkg: shared types, function codes and the rule match function
// for the first-match packet acl; no dependencies
package fmacl_pkg;

    localparam logic [2:0] FN_CHECK     = 3'd0;
    localparam logic [2:0] FN_ADD       = 3'd1;
    localparam logic [2:0] FN_DELETE    = 3'd2;
    localparam logic [2:0] FN_CLR_LIST  = 3'd3;
    localparam logic [2:0] FN_CLR_STATS = 3'd4;
    localparam logic [2:0] FN_QUERY     = 3'd5;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    localparam int ACT_ALLOW_BIT   = 0;
    localparam int ACT_MONITOR_BIT = 1;

    localparam logic [1:0] VERDICT_PASS  = 2'd0;
    localparam logic [1:0] VERDICT_DENY  = 2'd1;
    localparam logic [1:0] VERDICT_ALLOW = 2'd2;

    typedef struct packed {
        logic [2:0]  func;
        logic [1:0]  list_sel;
        logic [3:0]  rule_index;
        logic [31:0] src_ip;
        logic [31:0] src_mask;
        logic [31:0] dst_ip;
        logic [31:0] dst_mask;
        logic [7:0]  protocol;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [1:0]  action_flags;
        logic        is_ipv4;
    } t_acl_in;

    typedef struct packed {
        logic [1:0]  verdict;
        logic        monitor;
        logic [3:0]  matched_rule;
        logic        op_ok;
        logic [4:0]  rule_count;
        logic [31:0] allowed_total;
        logic [31:0] denied_total;
        logic [31:0] nomatch_total;
        logic [31:0] rule_hits;
    } t_acl_out;

    // classified operation handed from front to back
    typedef enum logic [2:0] {
        OP_CHECK,
        OP_ADD,
        OP_DELETE,
        OP_CLR_LIST,
        OP_CLR_STATS,
        OP_QUERY,
        OP_REPORT,
        OP_NULL
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [1:0]  list_sel;
        logic [3:0]  rule_index;
        logic [31:0] src;
        logic [31:0] src_mask;
        logic [31:0] dst;
        logic [31:0] dst_mask;
        logic [7:0]  proto;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [1:0]  action;
    } t_cmd;

    typedef struct packed {
        logic [31:0] src;
        logic [31:0] src_mask;
        logic [31:0] dst;
        logic [31:0] dst_mask;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  proto;
        logic [1:0]  action;
    } t_rule;

    function automatic t_rule rule_from_cmd(t_cmd c);
        t_rule r;
        r.src      = c.src;
        r.src_mask = c.src_mask;
        r.dst      = c.dst;
        r.dst_mask = c.dst_mask;
        r.sport    = c.sport;
        r.dport    = c.dport;
        r.proto    = c.proto;
        r.action   = c.action;
        return r;
    endfunction

    function automatic logic rule_match(t_rule r, t_cmd c);
        logic ports_used;
        logic l4;
        logic port_ok;
        ports_used = (r.sport != 16'd0) || (r.dport != 16'd0);
        l4         = (c.proto == PROTO_TCP) || (c.proto == PROTO_UDP);
        port_ok    = l4 && ((r.sport == 16'd0) || (r.sport == c.sport))
                        && ((r.dport == 16'd0) || (r.dport == c.dport));
        return ((r.proto == 8'd0) || (r.proto == c.proto))
            && ((c.src & r.src_mask) == r.src)
            && ((c.dst & r.dst_mask) == r.dst)
            && (!ports_used || port_ok);
    endfunction

endpackage

### hw/rtl/fmacl_front.sv
// fmacl_front: accepts items and classifies them into back-end commands
// depends on fmacl_pkg
module fmacl_front #(
    parameter int NUM_LISTS      = 4,
    parameter int RULES_PER_LIST = 16
) (
    input  logic               i_valid,
    output logic               o_ready,
    input  fmacl_pkg::t_acl_in i_item,
    output logic               o_push,
    output fmacl_pkg::t_cmd    o_cmd,
    input  logic               i_full
);
    import fmacl_pkg::*;

    logic in_range;
    logic idx_ok;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        in_range = 32'(i_item.list_sel) < 32'(NUM_LISTS);
        idx_ok   = 32'(i_item.rule_index) < 32'(RULES_PER_LIST);

        o_cmd.list_sel   = i_item.list_sel;
        o_cmd.rule_index = i_item.rule_index;
        o_cmd.src_mask   = i_item.src_mask;
        o_cmd.dst_mask   = i_item.dst_mask;
        o_cmd.proto      = i_item.protocol;
        o_cmd.sport      = i_item.sport;
        o_cmd.dport      = i_item.dport;
        o_cmd.action     = i_item.action_flags;
        o_cmd.src        = i_item.src_ip;
        o_cmd.dst        = i_item.dst_ip;

        unique case (i_item.func)
            FN_CHECK:     o_cmd.op = i_item.is_ipv4 ? OP_CHECK : OP_REPORT;
            FN_ADD: begin
                o_cmd.op  = OP_ADD;
                // rules are stored pre-masked
                o_cmd.src = i_item.src_ip & i_item.src_mask;
                o_cmd.dst = i_item.dst_ip & i_item.dst_mask;
            end
            FN_DELETE:    o_cmd.op = idx_ok ? OP_DELETE : OP_REPORT;
            FN_CLR_LIST:  o_cmd.op = OP_CLR_LIST;
            FN_CLR_STATS: o_cmd.op = OP_CLR_STATS;
            FN_QUERY:     o_cmd.op = idx_ok ? OP_QUERY : OP_REPORT;
            default:      o_cmd.op = OP_REPORT;
        endcase

        if (!in_range) begin
            o_cmd.op = OP_NULL;
        end
    end

endmodule

### hw/rtl/fmacl_queue.sv
// fmacl_queue: two-entry command queue between front and back
// depends on fmacl_pkg
module fmacl_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  fmacl_pkg::t_cmd i_cmd,
    output logic            o_full,
    output logic            o_valid,
    output fmacl_pkg::t_cmd o_cmd,
    input  logic            i_pop
);
    import fmacl_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

endmodule

### hw/rtl/fmacl_back.sv
// fmacl_back: executes commands against rule memory, counters and fill counts
// depends on fmacl_pkg
module fmacl_back #(
    parameter int NUM_LISTS      = 4,
    parameter int RULES_PER_LIST = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  fmacl_pkg::t_cmd     i_cmd,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output fmacl_pkg::t_acl_out o_item
);
    import fmacl_pkg::*;

    localparam int CW    = $clog2(RULES_PER_LIST + 1);
    localparam int LW    = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam int DEPTH = NUM_LISTS * RULES_PER_LIST;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EXEC = 6'b000010,
        S_CHK  = 6'b000100,
        S_DEL  = 6'b001000,
        S_CLS  = 6'b010000,
        S_QWT  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    t_cmd   r_cmd, n_cmd;
    logic [CW-1:0] r_ptr, n_ptr;
    logic [CW-1:0] r_slot, n_slot;
    logic r_pend, n_pend;

    logic [CW-1:0] r_count [NUM_LISTS];
    logic [CW-1:0] n_count [NUM_LISTS];
    logic [31:0] r_allow [NUM_LISTS];
    logic [31:0] n_allow [NUM_LISTS];
    logic [31:0] r_deny [NUM_LISTS];
    logic [31:0] n_deny [NUM_LISTS];
    logic [31:0] r_nomatch [NUM_LISTS];
    logic [31:0] n_nomatch [NUM_LISTS];

    t_rule       rule_mem [DEPTH];
    logic [31:0] hit_mem [DEPTH];
    t_rule       r_rd_rule;
    logic [31:0] r_rd_hit;

    t_acl_out r_out, n_out;
    logic     r_out_valid, n_out_valid;

    logic [LW-1:0] li;
    logic [31:0]   base;
    logic [CW-1:0] cnt;
    logic          idx_lt_cnt;
    logic          hit;
    logic          done;
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;
    logic          rule_we;
    logic          hit_we;
    t_rule         rule_wdata;
    logic [31:0]   hit_wdata;
    logic [1:0]    res_verdict;
    logic          res_monitor;
    logic [3:0]    res_matched;
    logic          res_ok;
    logic [31:0]   res_hits;

    assign o_valid = r_out_valid;
    assign o_item  = r_out;
    assign o_pop   = (r_state == S_IDLE) && i_q_valid && (!r_out_valid || i_ready);

    always_comb begin
        li         = LW'(r_cmd.list_sel);
        base       = 32'(li) * 32'(RULES_PER_LIST);
        cnt        = r_count[li];
        idx_lt_cnt = 32'(r_cmd.rule_index) < 32'(cnt);
        hit        = rule_match(r_rd_rule, r_cmd);

        n_state     = r_state;
        n_cmd       = r_cmd;
        n_ptr       = r_ptr;
        n_slot      = r_slot;
        n_pend      = r_pend;
        n_count     = r_count;
        n_allow     = r_allow;
        n_deny      = r_deny;
        n_nomatch   = r_nomatch;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        done        = 1'b0;
        raddr       = AW'(base + 32'(r_ptr));
        waddr       = AW'(base + 32'(r_ptr));
        rule_we     = 1'b0;
        hit_we      = 1'b0;
        rule_wdata  = r_rd_rule;
        hit_wdata   = r_rd_hit;
        res_verdict = VERDICT_PASS;
        res_monitor = 1'b0;
        res_matched = 4'd0;
        res_ok      = 1'b0;
        res_hits    = 32'd0;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    n_cmd   = i_cmd;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_cmd.op)
                    OP_CHECK: begin
                        n_ptr   = '0;
                        n_pend  = 1'b0;
                        n_state = S_CHK;
                    end
                    OP_ADD: begin
                        if (32'(cnt) < 32'(RULES_PER_LIST)) begin
                            rule_we     = 1'b1;
                            hit_we      = 1'b1;
                            waddr       = AW'(base + 32'(cnt));
                            rule_wdata  = rule_from_cmd(r_cmd);
                            hit_wdata   = 32'd0;
                            n_count[li] = cnt + CW'(1);
                            res_ok      = 1'b1;
                        end
                        done = 1'b1;
                    end
                    OP_DELETE: begin
                        if (idx_lt_cnt) begin
                            n_ptr   = CW'(32'(r_cmd.rule_index) + 32'd1);
                            n_pend  = 1'b0;
                            n_state = S_DEL;
                        end else begin
                            done = 1'b1;
                        end
                    end
                    OP_CLR_LIST: begin
                        n_count[li] = '0;
                        done        = 1'b1;
                    end
                    OP_CLR_STATS: begin
                        n_allow[li]   = 32'd0;
                        n_deny[li]    = 32'd0;
                        n_nomatch[li] = 32'd0;
                        n_ptr         = '0;
                        n_state       = S_CLS;
                    end
                    OP_QUERY: begin
                        if (idx_lt_cnt) begin
                            raddr   = AW'(base + 32'(r_cmd.rule_index));
                            n_state = S_QWT;
                        end else begin
                            done = 1'b1;
                        end
                    end
                    default: done = 1'b1;
                endcase
            end
            S_CHK: begin
                if (r_pend && hit) begin
                    hit_we      = 1'b1;
                    waddr       = AW'(base + 32'(r_slot));
                    hit_wdata   = r_rd_hit + 32'd1;
                    res_hits    = r_rd_hit + 32'd1;
                    res_matched = 4'(r_slot);
                    res_monitor = r_rd_rule.action[ACT_MONITOR_BIT];
                    if (r_rd_rule.action[ACT_ALLOW_BIT]) begin
                        res_verdict = VERDICT_ALLOW;
                        n_allow[li] = r_allow[li] + 32'd1;
                    end else begin
                        res_verdict = VERDICT_DENY;
                        n_deny[li]  = r_deny[li] + 32'd1;
                    end
                    done = 1'b1;
                end else if (!r_pend && (r_ptr >= cnt)) begin
                    n_nomatch[li] = r_nomatch[li] + 32'd1;
                    done          = 1'b1;
                end else if (r_ptr < cnt) begin
                    n_ptr  = r_ptr + CW'(1);
                    n_slot = r_ptr;
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
            end
            S_DEL: begin
                // shift the entry read last cycle one slot down
                if (r_pend) begin
                    rule_we = 1'b1;
                    hit_we  = 1'b1;
                    waddr   = AW'(base + 32'(r_slot) - 32'd1);
                end
                if (!r_pend && (r_ptr >= cnt)) begin
                    n_count[li] = cnt - CW'(1);
                    res_ok      = 1'b1;
                    done        = 1'b1;
                end else if (r_ptr < cnt) begin
                    n_ptr  = r_ptr + CW'(1);
                    n_slot = r_ptr;
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
            end
            S_CLS: begin
                if (r_ptr < cnt) begin
                    hit_we    = 1'b1;
                    hit_wdata = 32'd0;
                    n_ptr     = r_ptr + CW'(1);
                end else begin
                    done = 1'b1;
                end
            end
            S_QWT: begin
                res_hits = r_rd_hit;
                done     = 1'b1;
            end
            default: n_state = S_IDLE;
        endcase

        if (done) begin
            n_state     = S_IDLE;
            n_out_valid = 1'b1;
            if (r_cmd.op == OP_NULL) begin
                n_out = '0;
            end else begin
                n_out.verdict       = res_verdict;
                n_out.monitor       = res_monitor;
                n_out.matched_rule  = res_matched;
                n_out.op_ok         = res_ok;
                n_out.rule_count    = 5'(n_count[li]);
                n_out.allowed_total = n_allow[li];
                n_out.denied_total  = n_deny[li];
                n_out.nomatch_total = n_nomatch[li];
                n_out.rule_hits     = res_hits;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int l = 0; l < NUM_LISTS; l++) begin
                r_count[l]   <= '0;
                r_allow[l]   <= 32'd0;
                r_deny[l]    <= 32'd0;
                r_nomatch[l] <= 32'd0;
            end
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
            r_allow     <= n_allow;
            r_deny      <= n_deny;
            r_nomatch   <= n_nomatch;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_ptr  <= n_ptr;
        r_slot <= n_slot;
        r_out  <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (rule_we) begin
            rule_mem[waddr] <= rule_wdata;
        end
        if (hit_we) begin
            hit_mem[waddr] <= hit_wdata;
        end
        r_rd_rule <= rule_mem[raddr];
        r_rd_hit  <= hit_mem[raddr];
    end

endmodule

### hw/rtl/first_match_packet_acl.sv
// first_match_packet_acl: top level of the first-match five-tuple packet acl
// depends on fmacl_pkg, fmacl_front, fmacl_queue, fmacl_back
//
// Each item takes one operation (check, add, delete, clear list, clear
// stats, query) on one of NUM_LISTS rule lists and returns exactly one
// result item. Rules live in a single-port-write, registered-read memory of
// NUM_LISTS*RULES_PER_LIST entries; each list keeps rules packed from slot 0
// with a fill count, so nothing needs a clearing pass after reset. The back
// end reads one rule per cycle: a check walks the list up to the first match
// or the fill count, a delete moves each rule above the index down a slot,
// a stats clear zeroes the hit count of each filled slot, and a query reads
// one slot. A two-entry queue lets the input side keep taking items while
// the back end works or a result waits to be taken.
module first_match_packet_acl #(
    parameter int NUM_LISTS      = 4,
    parameter int RULES_PER_LIST = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  fmacl_pkg::t_acl_in  i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output fmacl_pkg::t_acl_out o_item
);
    import fmacl_pkg::*;

    // front to queue
    logic push;
    t_cmd push_cmd;
    logic q_full;
    // queue to back
    logic q_valid;
    t_cmd q_cmd;
    logic q_pop;

    // decode and range checks on the incoming item
    fmacl_front #(
        .NUM_LISTS      (NUM_LISTS),
        .RULES_PER_LIST (RULES_PER_LIST)
    ) u_front (
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_push  (push),
        .o_cmd   (push_cmd),
        .i_full  (q_full)
    );

    // decouples item intake from rule walking
    fmacl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    // rule memory walker, counters and result register
    fmacl_back #(
        .NUM_LISTS      (NUM_LISTS),
        .RULES_PER_LIST (RULES_PER_LIST)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (q_cmd),
        .o_pop     (q_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_item    (o_item)
    );

endmodule

### hw/rtl/fmacl_chk.sv
// fmacl_chk: port-level checks on the acl result channel, bound to the top
// depends on fmacl_pkg and first_match_packet_acl
module fmacl_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_valid,
    input logic                i_ready,
    input fmacl_pkg::t_acl_out o_item
);
    import fmacl_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_item))
        else $error("result changed while stalled");

    // no result right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // pass or no match carries no rule info
    a_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.verdict == VERDICT_PASS |->
            !o_item.monitor && o_item.matched_rule == 4'd0)
        else $error("rule info without a match");

    // add and delete success never comes with a verdict or hits
    a_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.op_ok |->
            o_item.verdict == VERDICT_PASS && o_item.rule_hits == 32'd0)
        else $error("op_ok mixed with check result");

endmodule

bind first_match_packet_acl fmacl_chk u_chk (.*);

### tb/sv/first_match_packet_acl_tb.sv
`timescale 1ns / 1ps
// first_match_packet_acl_tb: self-checking bench for the first-match packet acl
// depends on fmacl_pkg and first_match_packet_acl; drives items, predicts results
module first_match_packet_acl_tb;
    import fmacl_pkg::*;

    localparam int LISTS = 4;
    localparam int SLOTS = 16;
    localparam int N_RANDOM = 1930;

    // function codes with no operation behind them
    localparam logic [2:0] FN_SPARE_LO = 3'd6;
    localparam logic [2:0] FN_SPARE_HI = 3'd7;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    t_acl_in  in_item;
    logic     out_valid;
    logic     out_ready;
    t_acl_out out_item;

    first_match_packet_acl #(.NUM_LISTS(LISTS), .RULES_PER_LIST(SLOTS)) DUT (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_ready(in_ready), .i_item(in_item),
        .o_valid(out_valid), .i_ready(out_ready), .o_item(out_item)
    );

    // shadow rule table and per-list counters
    typedef struct packed {
        logic        valid;
        logic [31:0] src;
        logic [31:0] src_mask;
        logic [31:0] dst;
        logic [31:0] dst_mask;
        logic [7:0]  proto;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [1:0]  action;
        logic [31:0] hits;
    } t_shadow_rule;

    t_shadow_rule acl_rules [LISTS][SLOTS];
    logic [31:0]  cnt_allow [LISTS];
    logic [31:0]  cnt_deny [LISTS];
    logic [31:0]  cnt_nomatch [LISTS];

    t_acl_out pending_results[$];
    int       errors = 0;
    bit       calm = 0;      // last part of the run: no idling
    bit       hold_long = 0; // receiver long hold-off request

    initial begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial begin
        #20000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic t_shadow_rule blank_rule();
        t_shadow_rule r;
        r = '0;
        return r;
    endfunction

    function automatic logic rule_hits_packet(t_shadow_rule r, t_acl_in p);
        logic ports_on;
        if (!r.valid) return 1'b0;
        if (r.proto != 8'd0 && r.proto != p.protocol) return 1'b0;
        if ((p.src_ip & r.src_mask) != r.src) return 1'b0;
        if ((p.dst_ip & r.dst_mask) != r.dst) return 1'b0;
        ports_on = (r.sport != 16'd0) || (r.dport != 16'd0);
        if (ports_on) begin
            if (p.protocol != PROTO_TCP && p.protocol != PROTO_UDP) return 1'b0;
            if (r.sport != 16'd0 && r.sport != p.sport) return 1'b0;
            if (r.dport != 16'd0 && r.dport != p.dport) return 1'b0;
        end
        return 1'b1;
    endfunction

    // advance the shadow state by one item and return the expected result
    function automatic t_acl_out classify_and_update(t_acl_in p);
        t_acl_out o;
        int l;
        int k;
        bit found;
        o = '0;
        l = p.list_sel;
        if (l >= LISTS) return o;
        case (p.func)
            FN_CHECK: begin
                if (p.is_ipv4) begin
                    found = 0;
                    for (k = 0; k < SLOTS && !found; k++) begin
                        if (rule_hits_packet(acl_rules[l][k], p)) begin
                            found = 1;
                            acl_rules[l][k].hits++;
                            o.rule_hits    = acl_rules[l][k].hits;
                            o.matched_rule = 4'(k);
                            o.monitor      = acl_rules[l][k].action[ACT_MONITOR_BIT];
                            if (acl_rules[l][k].action[ACT_ALLOW_BIT]) begin
                                o.verdict = VERDICT_ALLOW;
                                cnt_allow[l]++;
                            end else begin
                                o.verdict = VERDICT_DENY;
                                cnt_deny[l]++;
                            end
                        end
                    end
                    if (!found) cnt_nomatch[l]++;
                end
            end
            FN_ADD: begin
                found = 0;
                for (k = 0; k < SLOTS && !found; k++) begin
                    if (!acl_rules[l][k].valid) begin
                        found = 1;
                        acl_rules[l][k].valid    = 1'b1;
                        acl_rules[l][k].src      = p.src_ip & p.src_mask;
                        acl_rules[l][k].src_mask = p.src_mask;
                        acl_rules[l][k].dst      = p.dst_ip & p.dst_mask;
                        acl_rules[l][k].dst_mask = p.dst_mask;
                        acl_rules[l][k].proto    = p.protocol;
                        acl_rules[l][k].sport    = p.sport;
                        acl_rules[l][k].dport    = p.dport;
                        acl_rules[l][k].action   = p.action_flags;
                        acl_rules[l][k].hits     = '0;
                        o.op_ok = 1'b1;
                    end
                end
            end
            FN_DELETE: begin
                if (acl_rules[l][p.rule_index].valid) begin
                    acl_rules[l][p.rule_index] = blank_rule();
                    for (k = p.rule_index; k + 1 < SLOTS; k++) begin
                        if (!acl_rules[l][k + 1].valid) break;
                        acl_rules[l][k] = acl_rules[l][k + 1];
                        acl_rules[l][k + 1] = blank_rule();
                    end
                    o.op_ok = 1'b1;
                end
            end
            FN_CLR_LIST: begin
                for (k = 0; k < SLOTS; k++) acl_rules[l][k] = blank_rule();
            end
            FN_CLR_STATS: begin
                cnt_allow[l] = '0;
                cnt_deny[l] = '0;
                cnt_nomatch[l] = '0;
                for (k = 0; k < SLOTS; k++) acl_rules[l][k].hits = '0;
            end
            FN_QUERY: begin
                if (acl_rules[l][p.rule_index].valid)
                    o.rule_hits = acl_rules[l][p.rule_index].hits;
            end
            default: ;
        endcase
        for (k = 0; k < SLOTS; k++)
            if (acl_rules[l][k].valid) o.rule_count++;
        o.allowed_total = cnt_allow[l];
        o.denied_total  = cnt_deny[l];
        o.nomatch_total = cnt_nomatch[l];
        return o;
    endfunction

    // directed rows: item plus an optional typed-in expectation
    typedef struct {
        t_acl_in  item;
        bit       fixed;
        t_acl_out result;
    } t_row;

    t_row directed[$];

    function automatic t_acl_in mk(logic [2:0] f, logic [1:0] l, logic [3:0] idx,
                                   logic [31:0] s, logic [31:0] sm,
                                   logic [31:0] d, logic [31:0] dm,
                                   logic [7:0] pr, logic [15:0] sp, logic [15:0] dp,
                                   logic [1:0] act, logic v4);
        t_acl_in p;
        p.func = f; p.list_sel = l; p.rule_index = idx;
        p.src_ip = s; p.src_mask = sm; p.dst_ip = d; p.dst_mask = dm;
        p.protocol = pr; p.sport = sp; p.dport = dp;
        p.action_flags = act; p.is_ipv4 = v4;
        return p;
    endfunction

    function automatic t_acl_out exp_counts(logic [4:0] n, logic [31:0] nm);
        t_acl_out o;
        o = '0;
        o.rule_count = n;
        o.nomatch_total = nm;
        return o;
    endfunction

    task automatic add_row(t_acl_in p, bit fx = 0, t_acl_out r = '0);
        t_row row;
        row.item = p;
        row.fixed = fx;
        row.result = r;
        directed.push_back(row);
    endtask

    // random item biased toward addresses that real rules will match
    function automatic t_acl_in rand_item();
        t_acl_in p;
        logic [223:0] raw;
        int sel;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        p = raw[$bits(t_acl_in)-1:0];
        sel = $urandom_range(99);
        if (sel < 45) p.func = FN_CHECK;
        else if (sel < 70) p.func = FN_ADD;
        else if (sel < 82) p.func = FN_DELETE;
        else if (sel < 85) p.func = FN_CLR_LIST;
        else if (sel < 88) p.func = FN_CLR_STATS;
        else if (sel < 97) p.func = FN_QUERY;
        else p.func = ($urandom_range(1) == 0) ? FN_SPARE_LO : FN_SPARE_HI;
        p.list_sel = ($urandom_range(9) == 0) ? 2'($urandom_range(3)) : 2'($urandom_range(1));
        if ($urandom_range(3) != 0) begin
            p.src_ip   = {8'd10, 16'd0, 6'd0, p.src_ip[1:0]};
            p.dst_ip   = {8'd192, 16'd0, 6'd0, p.dst_ip[1:0]};
            p.src_mask = $urandom_range(1) ? 32'hFFFF_FFFC : 32'hFFFF_FFFF;
            p.dst_mask = $urandom_range(1) ? 32'h0 : 32'hFFFF_FFFF;
            p.sport    = $urandom_range(1) ? 16'd0 : 16'($urandom_range(3));
            p.dport    = $urandom_range(1) ? 16'd0 : 16'($urandom_range(3));
            case ($urandom_range(3))
                0: p.protocol = 8'd0;
                1: p.protocol = PROTO_TCP;
                2: p.protocol = PROTO_UDP;
                default: p.protocol = 8'd1;
            endcase
            p.is_ipv4 = ($urandom_range(9) != 0);
        end
        return p;
    endfunction

    // sender: drives one item and waits for acceptance, with random gaps
    task automatic send_item(t_acl_in p);
        int gap;
        if (!calm && $urandom_range(3) == 0) begin
            in_valid <= 1'b0;
            gap = $urandom_range(19, 1);
            repeat (gap) @(posedge clk);
        end
        in_item  <= p;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        int n;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            if (hold_long) begin
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_long = 0;
            end else if (!calm && $urandom_range(3) == 0) begin
                out_ready <= 1'b0;
                n = $urandom_range(19, 1);
                repeat (n) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
                n = $urandom_range(19, 1);
                repeat (n) @(posedge clk);
            end
        end
    end

    // result checker: compare each taken result with the oldest expectation
    always @(posedge clk) begin
        t_acl_out want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected, actual %p", $time, out_item);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (out_item.verdict !== want.verdict ||
                    out_item.monitor !== want.monitor ||
                    out_item.matched_rule !== want.matched_rule ||
                    out_item.op_ok !== want.op_ok ||
                    out_item.rule_count !== want.rule_count ||
                    out_item.allowed_total !== want.allowed_total ||
                    out_item.denied_total !== want.denied_total ||
                    out_item.nomatch_total !== want.nomatch_total ||
                    out_item.rule_hits !== want.rule_hits) begin
                    $display("%0t: mismatch expected %p actual %p", $time, want, out_item);
                    errors++;
                end
            end
        end
    end

    initial begin
        t_acl_out exp_res;
        t_acl_out okres;
        int i;
        int wait_cycles;
        in_valid <= 1'b0;
        in_item  <= '0;
        rst_n    <= 1'b0;
        for (i = 0; i < LISTS; i++) begin
            cnt_allow[i] = '0; cnt_deny[i] = '0; cnt_nomatch[i] = '0;
            for (int k = 0; k < SLOTS; k++) acl_rules[i][k] = blank_rule();
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed part: empty list, extremes, every function and special case
        add_row(mk(FN_CHECK, 0, 0, '1, '1, '1, '1, '1, '1, '1, 2'd3, 1), 1,
                exp_counts(0, 1));
        add_row(mk(FN_CHECK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, exp_counts(0, 1));
        add_row(mk(FN_QUERY, 0, 4'd15, '1, '1, '1, '1, '1, '1, '1, 2'd3, 1), 1,
                exp_counts(0, 1));
        add_row(mk(FN_DELETE, 1, 4'd0, 0, 0, 0, 0, 0, 0, 0, 0, 1), 1, exp_counts(0, 0));
        add_row(mk(FN_CHECK, 2'd3, 0, '1, '1, '1, '1, 8'd6, '1, '1, 2'd3, 1), 1,
                exp_counts(0, 1));
        okres = exp_counts(1, 1);
        okres.op_ok = 1'b1;
        add_row(mk(FN_ADD, 0, 0, 32'h0A00_0001, 32'hFFFF_FF00, 32'hC0A8_0101, '1,
                   PROTO_TCP, 16'd0, 16'd80, 2'd3, 0), 1, okres);
        add_row(mk(FN_ADD, 0, 0, 0, 0, 0, 0, 8'd0, 0, 0, 2'd0, 0));
        add_row(mk(FN_ADD, 0, 0, '1, '1, '1, '1, '1, '1, '1, 2'd2, 1));
        add_row(mk(FN_CHECK, 0, 0, 32'h0A00_0077, 0, 32'hC0A8_0101, 0, PROTO_TCP,
                   16'd5, 16'd80, 0, 1));
        add_row(mk(FN_CHECK, 0, 0, 32'h0A00_0077, 0, 32'hC0A8_0101, 0, PROTO_UDP,
                   16'd5, 16'd81, 0, 1));
        add_row(mk(FN_CHECK, 0, 0, 32'h0A00_0077, 0, 32'hC0A8_0101, 0, 8'd1,
                   0, 16'd80, 0, 0));
        add_row(mk(FN_QUERY, 0, 4'd0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
        add_row(mk(FN_QUERY, 0, 4'd1, 0, 0, 0, 0, 0, 0, 0, 0, 1));
        add_row(mk(FN_SPARE_LO, 0, 4'd0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
        add_row(mk(FN_SPARE_HI, 0, 4'd1, 0, 0, 0, 0, 0, 0, 0, 0, 1));
        add_row(mk(FN_DELETE, 0, 4'd0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
        add_row(mk(FN_CLR_STATS, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
        for (i = 0; i < 17; i++)   // fill list 3 past its end
            add_row(mk(FN_ADD, 3, 0, i, '1, 0, 0, 8'd0, 0, 0, i[1:0], 1));
        add_row(mk(FN_DELETE, 3, 4'd15, 0, 0, 0, 0, 0, 0, 0, 0, 1));
        add_row(mk(FN_DELETE, 3, 4'd3, 0, 0, 0, 0, 0, 0, 0, 0, 1));
        add_row(mk(FN_CHECK, 3, 0, 32'd4, 0, 0, 0, 8'd0, 0, 0, 0, 1));
        add_row(mk(FN_CLR_LIST, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));

        foreach (directed[j]) begin
            exp_res = classify_and_update(directed[j].item);
            if (directed[j].fixed && exp_res !== directed[j].result) begin
                $display("%0t: table row %0d expected %p model %p", $time, j,
                         directed[j].result, exp_res);
                errors++;
            end
            pending_results.push_back(exp_res);
            send_item(directed[j].item);
        end

        // random part; long receiver hold-off early on, calm at the end
        for (i = 0; i < N_RANDOM; i++) begin
            t_acl_in p;
            if (i == 200) hold_long = 1;
            if (i == N_RANDOM - 150) calm = 1;
            p = rand_item();
            pending_results.push_back(classify_and_update(p));
            send_item(p);
        end
        in_valid <= 1'b0;

        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 20000) begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (40) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
